### rtl/core/sha4bm_pkg.sv
// Shared types, constants and round functions for the four-byte SHA-256 matcher.
// Used by sha4bm_round, sha4bm_digest and sha256_four_byte_match.
package sha4bm_pkg;

    localparam int NUM_ROUNDS  = 64;
    localparam int NUM_TARGETS = 8;
    localparam int WIN_WORDS   = 16;

    // Fixed padding of a single 32-bit message into one block
    localparam logic [31:0] PAD_WORD   = 32'h8000_0000;
    localparam logic [31:0] BIT_LENGTH = 32'd32;

    // Index 0 holds working variable a (or digest word 0)
    typedef logic [7:0][31:0] hash_state_t;
    // Index 0 holds the schedule word consumed by the current round
    typedef logic [WIN_WORDS-1:0][31:0] sched_win_t;
    typedef logic [NUM_TARGETS-1:0][31:0] target_words_t;

    // Payload carried from one round stage to the next
    typedef struct packed {
        hash_state_t st;
        sched_win_t  win;
    } round_data_t;

    // One request held in the output queue
    typedef struct packed {
        hash_state_t digest;
        logic        match;
    } result_t;

    localparam hash_state_t HASH_IV = {
        32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
        32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
    };

    localparam logic [31:0] ROUND_K [NUM_ROUNDS] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
    endfunction

    function automatic logic [31:0] sha_choose(input logic [31:0] e, input logic [31:0] f,
                                               input logic [31:0] g);
        return (e & f) ^ (~e & g);
    endfunction

    function automatic logic [31:0] sha_majority(input logic [31:0] a, input logic [31:0] b,
                                                 input logic [31:0] c);
        return (a & b) ^ (a & c) ^ (b & c);
    endfunction

endpackage

### rtl/core/sha256_four_byte_match.sv
// One candidate enters per clock while the output queue has room. The path is 64 registered
// round stages (one SHA-256 round and one schedule word each), a feed-forward and compare
// stage, and a two-entry output queue. The whole pipeline advances together while the queue
// has room, so a result side that stalls for long stops input once the queue holds two
// results; sustained throughput is one candidate per cycle. The user must write target words
// over the register port only while no requests are in flight; the block does not enforce it.
// Depends on sha4bm_pkg, sha4bm_round and sha4bm_digest.
module sha256_four_byte_match
    import sha4bm_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    // Candidate stream
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [31:0]  s_axis_tdata,   // [31:0] message_word
    // Result stream
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [255:0] m_axis_tdata,   // [63:0] digest_high_pair, [127:64] digest_second_pair,
                                         // [191:128] digest_third_pair, [255:192] digest_low_pair
    output logic [0:0]   m_axis_tuser,   // [0] is_match
    // Register port
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    target_words_t target_reg;
    logic          reg_write;

    logic          en;
    logic          round_valid [NUM_ROUNDS+1];
    round_data_t   round_data  [NUM_ROUNDS+1];

    logic          dig_valid;
    result_t       dig_result;

    result_t       slot_reg [2];
    logic [1:0]    fill_reg;
    logic [1:0]    fill_next;
    logic          push;
    logic          pop;

    // Register port: writes complete in the access phase
    assign pready    = 1'b1;
    assign reg_write = psel && penable && pwrite && pready;
    assign prdata    = target_reg[paddr[4:2]];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_reg <= '0;
        end else if (reg_write) begin
            target_reg[paddr[4:2]] <= pwdata;
        end
    end

    // Advance the pipeline while the output queue has room
    assign en            = (fill_reg != 2'd2);
    assign s_axis_tready = en;

    // Pad the candidate into a single block
    always_comb begin
        round_valid[0]    = s_axis_tvalid;
        round_data[0].st  = HASH_IV;
        round_data[0].win = '0;
        round_data[0].win[0]           = s_axis_tdata;
        round_data[0].win[1]           = PAD_WORD;
        round_data[0].win[WIN_WORDS-1] = BIT_LENGTH;
    end

    // Round stages
    for (genvar i = 0; i < NUM_ROUNDS; i++) begin : g_round
        sha4bm_round u_round (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .round_k   (ROUND_K[i]),
            .in_valid  (round_valid[i]),
            .in_data   (round_data[i]),
            .out_valid (round_valid[i+1]),
            .out_data  (round_data[i+1])
        );
    end

    sha4bm_digest u_digest (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .in_valid   (round_valid[NUM_ROUNDS]),
        .in_state   (round_data[NUM_ROUNDS].st),
        .targets    (target_reg),
        .out_valid  (dig_valid),
        .out_result (dig_result)
    );

    // Output queue: slot 0 is the head
    assign push = en && dig_valid;
    assign pop  = m_axis_tvalid && m_axis_tready;

    always_comb begin
        fill_next = fill_reg;
        if (push && !pop) begin
            fill_next = fill_reg + 2'd1;
        end else if (pop && !push) begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= 2'd0;
        end else begin
            fill_reg <= fill_next;
        end
    end

    // Load a new request at the head when it lands there, else shift on a pop
    always_ff @(posedge aclk) begin
        if (push && fill_next == 2'd1) begin
            slot_reg[0] <= dig_result;
        end else if (pop) begin
            slot_reg[0] <= slot_reg[1];
        end
        if (push && fill_next == 2'd2) begin
            slot_reg[1] <= dig_result;
        end
    end

    assign m_axis_tvalid = (fill_reg != 2'd0);
    assign m_axis_tdata  = {slot_reg[0].digest[6], slot_reg[0].digest[7],
                            slot_reg[0].digest[4], slot_reg[0].digest[5],
                            slot_reg[0].digest[2], slot_reg[0].digest[3],
                            slot_reg[0].digest[0], slot_reg[0].digest[1]};
    assign m_axis_tuser  = slot_reg[0].match;

    // Queue never overfills
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg != 2'd3)
        else $error("output queue fill out of range");

    // A full queue stops the input side
    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (fill_reg == 2'd2) |-> !s_axis_tready && !push)
        else $error("pipeline advanced with a full output queue");

    // A lone push grows the queue by one
    a_push_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> fill_reg == $past(fill_reg) + 2'd1)
        else $error("output queue lost a request");

    // A lone pop shrinks the queue by one
    a_pop_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && !push) |=> fill_reg == $past(fill_reg) - 2'd1)
        else $error("output queue repeated a request");

endmodule

### rtl/core/sha4bm_round.sv
// One SHA-256 compression round as a pipeline stage, with its schedule window.
// Depends on sha4bm_pkg for the state types and round functions.
module sha4bm_round
    import sha4bm_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        en,
    input  logic [31:0] round_k,
    input  logic        in_valid,
    input  round_data_t in_data,
    output logic        out_valid,
    output round_data_t out_data
);

    logic        valid_reg;
    round_data_t data_reg;
    round_data_t data_next;
    logic [31:0] t1;
    logic [31:0] t2;
    logic [31:0] new_word;

    // Compress one round and slide the schedule window by one word
    always_comb begin
        t1 = in_data.st[7] + big_sigma1(in_data.st[4])
           + sha_choose(in_data.st[4], in_data.st[5], in_data.st[6])
           + round_k + in_data.win[0];
        t2 = big_sigma0(in_data.st[0])
           + sha_majority(in_data.st[0], in_data.st[1], in_data.st[2]);
        new_word = small_sigma1(in_data.win[14]) + in_data.win[9]
                 + small_sigma0(in_data.win[1]) + in_data.win[0];

        data_next.st[0] = t1 + t2;
        data_next.st[1] = in_data.st[0];
        data_next.st[2] = in_data.st[1];
        data_next.st[3] = in_data.st[2];
        data_next.st[4] = in_data.st[3] + t1;
        data_next.st[5] = in_data.st[4];
        data_next.st[6] = in_data.st[5];
        data_next.st[7] = in_data.st[6];

        for (int j = 0; j < WIN_WORDS - 1; j++) begin
            data_next.win[j] = in_data.win[j+1];
        end
        data_next.win[WIN_WORDS-1] = new_word;
    end

    // Advance valid bit with the stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    // Hold payload while stalled
    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

### rtl/core/sha4bm_digest.sv
// Final stage: add the initial hash values and compare against the target words.
// Depends on sha4bm_pkg for the state types and the initial hash constant.
module sha4bm_digest
    import sha4bm_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic          in_valid,
    input  hash_state_t   in_state,
    input  target_words_t targets,
    output logic          out_valid,
    output result_t       out_result
);

    logic        valid_reg;
    result_t     result_reg;
    result_t     result_next;

    // Feed forward the initial hash and check for a full match
    always_comb begin
        for (int j = 0; j < 8; j++) begin
            result_next.digest[j] = in_state[j] + HASH_IV[j];
        end
        result_next.match = (result_next.digest == targets);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            result_reg <= result_next;
        end
    end

    assign out_valid  = valid_reg;
    assign out_result = result_reg;

endmodule
